// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

  // Result queue geometry
  localparam int RES_DEPTH = 4;
  localparam int PTR_W     = $clog2(RES_DEPTH);
  localparam int CNT_W     = $clog2(RES_DEPTH + 1);
  localparam int MAX_RES   = 3;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_PAD = 8'h3D;  // '='
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       bad_char;
    logic       message_end;
    logic       run_end;
  } result_t;

  // Results released by one item, slot 0 first
  typedef struct packed {
    logic [1:0]                num;
    result_t [MAX_RES-1:0]     slot;
  } group_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- hdl/b64d_ifs.sv -----
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       final_char;

  modport source(output valid, symbol, final_char, input ready);
  modport sink(input valid, symbol, final_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       bad_char;
  logic       message_end;
  logic       run_end;

  modport source(output valid, data_byte, has_byte, bad_char, message_end, run_end,
                 input ready);
  modport sink(input valid, data_byte, has_byte, bad_char, message_end, run_end,
               output ready);
endinterface

// ----- hdl/b64d_decode.sv -----
module b64d_decode (
  input  logic              clk,
  input  logic              rst_n,
  b64d_in_if.sink           in_ch,
  input  logic              room,
  output b64d_pkg::group_t  grp
);
  import b64d_pkg::*;

  logic        in_valid_r;
  logic [7:0]  sym_r;
  logic        fin_r;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        drain_r, drain_nxt;
  logic        advance;
  logic        skip;
  sextet_t     sx;
  logic [23:0] w;
  group_t      g;

  // Release what the remainder still holds
  function automatic group_t flush_grp(input logic [17:0] acc, input logic [1:0] cnt);
    group_t f;
    f = '0;
    case (cnt)
      2'd2: begin
        f.num               = 2'd1;
        f.slot[0].data_byte = acc[11:4];
        f.slot[0].has_byte  = 1'b1;
      end
      2'd3: begin
        f.num               = 2'd2;
        f.slot[0].data_byte = acc[17:10];
        f.slot[0].has_byte  = 1'b1;
        f.slot[1].data_byte = acc[9:2];
        f.slot[1].has_byte  = 1'b1;
      end
      default: f.num = 2'd0;
    endcase
    return f;
  endfunction

  assign advance      = in_valid_r && room;
  assign in_ch.ready  = !in_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      sym_r <= in_ch.symbol;
      fin_r <= in_ch.final_char;
    end
  end

  always_comb begin
    sx        = sextet_of(sym_r);
    skip      = drain_r || sym_r == CH_LF || sym_r == CH_CR || sym_r == CH_SP;
    w         = {6'd0, acc_r} << 6 | {18'd0, sx.val};
    g         = '0;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;

    if (!skip) begin
      if (sym_r == CH_PAD) begin
        g         = flush_grp(acc_r, cnt_r);
        acc_nxt   = '0;
        cnt_nxt   = '0;
        drain_nxt = 1'b1;
      end else if (!sx.ok) begin
        g.num              = 2'd1;
        g.slot[0].bad_char = 1'b1;
        acc_nxt            = '0;
        cnt_nxt            = '0;
        drain_nxt          = 1'b1;
      end else if (cnt_r == 2'd3) begin
        g.num               = 2'd3;
        g.slot[0].data_byte = w[23:16];
        g.slot[1].data_byte = w[15:8];
        g.slot[2].data_byte = w[7:0];
        g.slot[0].has_byte  = 1'b1;
        g.slot[1].has_byte  = 1'b1;
        g.slot[2].has_byte  = 1'b1;
        acc_nxt             = '0;
        cnt_nxt             = '0;
      end else begin
        acc_nxt = w[17:0];
        cnt_nxt = cnt_r + 2'd1;
      end
    end

    if (fin_r) begin
      // A char that released something has already emptied the remainder
      if (g.num == 2'd0) begin
        g = flush_grp(acc_nxt, cnt_nxt);
      end
      if (g.num == 2'd0) begin
        g.num = 2'd1;  // empty end marker
      end
      acc_nxt   = '0;
      cnt_nxt   = '0;
      drain_nxt = 1'b0;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      if (g.num != 2'd0 && 2'(i) == g.num - 2'd1) begin
        g.slot[i].run_end     = 1'b1;
        g.slot[i].message_end = fin_r;
      end
    end

    if (!advance) begin
      g.num = 2'd0;
    end
    grp = g;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else if (advance) begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fin_r |=> cnt_r == 2'd0 && acc_r == 18'd0 && !drain_r)
    else $error("state not cleared after message end");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> cnt_r == 2'd0 && acc_r == 18'd0)
    else $error("values held while draining");

  a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fin_r |-> grp.num != 2'd0)
    else $error("final item released no result");

endmodule

// ----- hdl/b64d_res_queue.sv -----
module b64d_res_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  b64d_pkg::group_t  grp,
  output logic              room,
  b64d_out_if.source        out_ch
);
  import b64d_pkg::*;

  result_t              mem [RES_DEPTH];
  logic [PTR_W-1:0]     wp_r, rp_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pop;
  result_t              head;

  assign room = cnt_r <= CNT_W'(RES_DEPTH - MAX_RES);
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem[rp_r];

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.data_byte   = head.data_byte;
  assign out_ch.has_byte    = head.has_byte;
  assign out_ch.bad_char    = head.bad_char;
  assign out_ch.message_end = head.message_end;
  assign out_ch.run_end     = head.run_end;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < grp.num) begin
        mem[wp_r + PTR_W'(i)] <= grp.slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PTR_W'(grp.num);
      rp_r  <= rp_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(grp.num) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    grp.num != 2'd0 |-> cnt_r <= CNT_W'(RES_DEPTH - MAX_RES))
    else $error("push without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(RES_DEPTH))
    else $error("queue count past depth");

  a_bad_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_char |-> !out_ch.has_byte && out_ch.run_end)
    else $error("error result carries a byte");

endmodule

// ----- hdl/base64_stream_decoder.sv -----
// Data path: a character taken into the input register is decoded combinationally and its
//   results are written into the result queue, whose head drives the output port.
// Throughput: one character per cycle while the queue has room for three results. A quad
//   that releases three bytes holds input off until the queue is back to one entry, even
//   with the output always ready.
// Reset (rst_n low, synchronous): queue emptied, accumulator, count and drain cleared.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);
  import b64d_pkg::*;

  group_t grp;   // results released by the item leaving the input register
  logic   room;  // queue can take a full three-byte transaction

  // Input register, sextet lookup, accumulator and pad/drain handling
  b64d_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .grp   (grp)
  );

  // Result queue: take up to three results per cycle, hand out one per transaction
  b64d_res_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .grp    (grp),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ----- test/tb_base64_stream_decoder.sv -----
module tb_base64_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  // Longest legal stretch without any transaction on either side: the long
  // receiver hold plus random stalls stays far below this.
  localparam int QUIET_LIMIT  = 1000;
  // Cycles to linger once nothing is expected; a character's first result only
  // passes the input register and the result queue, so a handful is plenty.
  localparam int SETTLE_TAIL  = 8;
  localparam int LONG_HOLD    = 150;
  localparam int MAX_REPORTED = 10;

  logic clk;
  logic rst_n;

  b64d_in_if  in_ch();
  b64d_out_if out_ch();

  base64_stream_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decoder state as the testbench sees it
  logic [17:0] acc_bits;
  logic [1:0]  acc_count;
  logic        skipping;

  result_t pending_results[$];

  int src_idle_pct;
  int sink_stall_pct;
  int hold_request;
  int chars_sent;
  int fail_count;
  int mismatches_shown;

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Map a character to its 6-bit value; -1 when it is not in the alphabet.
  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic result_t byte_result(logic [7:0] b);
    result_t r;
    r = '0;
    r.data_byte = b;
    r.has_byte  = 1'b1;
    return r;
  endfunction

  // Release what a partial quad holds: two values make one byte, three make two.
  function automatic void release_tail(ref result_t run[$]);
    if (acc_count == 2'd2) begin
      run.insert(run.size(), byte_result(acc_bits[11:4]));
    end else if (acc_count == 2'd3) begin
      run.insert(run.size(), byte_result(acc_bits[17:10]));
      run.insert(run.size(), byte_result(acc_bits[9:2]));
    end
    acc_bits  = '0;
    acc_count = '0;
  endfunction

  // Advance the decoder by one accepted character and queue what it releases.
  function automatic void predict_decode(logic [7:0] c, logic fin);
    result_t     run[$];
    result_t     flag;
    int          v;
    logic [23:0] w;
    if (!skipping && c != CH_LF && c != CH_CR && c != CH_SP) begin
      if (c == CH_PAD) begin
        release_tail(run);
        skipping = 1'b1;
      end else begin
        v = sextet_value(c);
        if (v < 0) begin
          flag          = '0;
          flag.bad_char = 1'b1;
          run.insert(run.size(), flag);
          acc_bits  = '0;
          acc_count = '0;
          skipping  = 1'b1;
        end else begin
          w = {acc_bits, 6'(v)};
          if (acc_count == 2'd3) begin
            run.insert(run.size(), byte_result(w[23:16]));
            run.insert(run.size(), byte_result(w[15:8]));
            run.insert(run.size(), byte_result(w[7:0]));
            acc_bits  = '0;
            acc_count = '0;
          end else begin
            acc_bits  = w[17:0];
            acc_count = acc_count + 2'd1;
          end
        end
      end
    end
    if (fin) begin
      release_tail(run);
      // Nothing released: the message still closes with an empty marker
      if (run.size() == 0) run.insert(0, result_t'('0));
      run[run.size()-1].message_end = 1'b1;
      acc_bits  = '0;
      acc_count = '0;
      skipping  = 1'b0;
    end
    if (run.size() > 0) run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) pending_results.insert(pending_results.size(), run[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Character source
  // ---------------------------------------------------------------------------

  // Offer one character and hold it until the decoder takes it. Called and
  // left at a falling edge.
  task automatic send_char(input logic [7:0] sym, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.symbol     = sym;
    in_ch.final_char = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_decode(sym, fin);
    chars_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_text(input string s, input bit close_msg);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], close_msg && (i == s.len() - 1));
    end
  endtask

  // Hold the source until every queued result has come out, then settle.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_TAIL) @(negedge clk);
  endtask

  function automatic logic [7:0] alpha_char(int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    return (v == 62) ? 8'h2B : 8'h2F;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(2))
      0:       return CH_LF;
      1:       return CH_CR;
      default: return CH_SP;
    endcase
  endfunction

  // Any byte outside the alphabet, the blanks and the pad
  function automatic logic [7:0] invalid_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (sextet_value(c) >= 0 || c == CH_PAD || c == CH_LF || c == CH_CR || c == CH_SP)
      c = 8'($urandom_range(255));
    return c;
  endfunction

  // Build one message: mostly well-formed text, some broken, some noise.
  task automatic send_random_message();
    logic [7:0] msg[$];
    int         shape;
    int         nvals;
    shape = $urandom_range(99);
    nvals = $urandom_range(0, 12);
    for (int i = 0; i < nvals; i++) begin
      if ($urandom_range(9) == 0) msg.insert(msg.size(), blank_char());
      msg.insert(msg.size(), alpha_char($urandom_range(63)));
    end
    if (shape < 70) begin
      // well-formed; pad the partial quad half of the time
      if (nvals % 4 >= 2 && $urandom_range(1) == 1)
        repeat (4 - nvals % 4) msg.insert(msg.size(), CH_PAD);
    end else if (shape < 84) begin
      // a bad byte somewhere abandons the rest of the message
      msg.insert($urandom_range(msg.size()), invalid_char());
    end else if (shape < 92) begin
      // early pad; whatever follows it must be swallowed
      msg.insert($urandom_range(msg.size()), CH_PAD);
      repeat ($urandom_range(1, 3)) msg.insert(msg.size(), 8'($urandom_range(255)));
    end else begin
      msg.delete();
      repeat ($urandom_range(1, 6)) msg.insert(msg.size(), 8'($urandom_range(255)));
    end
    // Sometimes close on a blank, always when there is nothing else
    if (msg.size() == 0 || $urandom_range(7) == 0) msg.insert(msg.size(), blank_char());
    foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls plus an on-demand long hold
  // ---------------------------------------------------------------------------
  initial begin
    int held;
    held         = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        held         = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        out_ch.ready = 1'b0;
        held--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data_byte   = out_ch.data_byte;
      got.has_byte    = out_ch.has_byte;
      got.bad_char    = out_ch.bad_char;
      got.message_end = out_ch.message_end;
      got.run_end     = out_ch.run_end;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (mismatches_shown < MAX_REPORTED) begin
          mismatches_shown++;
          $display("%0t: unexpected result byte=%h has=%b bad=%b msg_end=%b run_end=%b",
                   $realtime, got.data_byte, got.has_byte, got.bad_char,
                   got.message_end, got.run_end);
        end
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (mismatches_shown < MAX_REPORTED) begin
            mismatches_shown++;
            $display("%0t: mismatch expected byte=%h has=%b bad=%b msg_end=%b run_end=%b",
                     $realtime, want.data_byte, want.has_byte, want.bad_char,
                     want.message_end, want.run_end);
            $display("%0t:            actual byte=%h has=%b bad=%b msg_end=%b run_end=%b",
                     $realtime, got.data_byte, got.has_byte, got.bad_char,
                     got.message_end, got.run_end);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: stop when neither side moves for too long
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked messages: full quad, pad mid-stream, pad on the last
  // character, lone value, extreme bytes, bad bytes while decoding and
  // while swallowing, bad byte as the last character.
  task automatic test_directed();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_text("TWFu", 1'b1);
    send_text("TWE=", 1'b0);
    send_char(CH_LF, 1'b1);
    send_text(" T\rQ=", 1'b1);
    send_text("T", 1'b1);
    send_text("////", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("A", 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h80, 1'b1);
    send_text("AA", 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_chars);
    int target;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    target         = chars_sent + n_chars;
    while (chars_sent < target) send_random_message();
    wait_drained();
  endtask

  // Block the sink for a long stretch while full quads keep coming, so the
  // result queue fills and the input stalls.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = LONG_HOLD;
    for (int i = 0; i < 24; i++) begin
      send_char(alpha_char($urandom_range(63)), i == 23);
    end
    wait_drained();
  endtask

  // Stop mid-message until every result is out, then finish the message.
  task automatic test_pause_mid_message();
    src_idle_pct   = 0;
    sink_stall_pct = 30;
    send_text("SGVsbG8", 1'b0);
    wait_drained();
    send_text("sIHdvcmxk", 1'b1);
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.symbol     = '0;
    in_ch.final_char = 1'b0;
    acc_bits         = '0;
    acc_count        = '0;
    skipping         = 1'b0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    hold_request     = 0;
    chars_sent       = 0;
    fail_count       = 0;
    mismatches_shown = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic(0, 0, 55);
    test_random_traffic(50, 0, 55);
    test_random_traffic(0, 50, 55);
    test_random_traffic(26, 26, 55);
    test_output_backpressure();
    test_pause_mid_message();

    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
